// ----- rtl/pstuq_pkg.sv -----
// ----------------------------------------------------------------------------
// pstuq_pkg: shared definitions for the prefix sum tree block
// Field widths, operation codes, controller states and the command/status
// structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package pstuq_pkg;

    localparam int DEF_N   = 65536;  // default tree size
    localparam int OP_W    = 2;
    localparam int IDX_W   = 17;
    localparam int DATA_W  = 32;
    localparam int S_TDATA_W = 56;   // index + delta, padded to bytes
    localparam int M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,   // clearing pass after reset
        ST_IDLE,
        ST_WALK,   // tree walk, one node per cycle
        ST_CLEAR,  // clear request sweep
        ST_DONE    // result waits for the output register
    } t_state;

    typedef struct packed {
        logic load;      // capture request and set up walk
        logic walk;      // advance walk
        logic clr_en;    // zero one entry
        logic out_load;  // move result into output register
    } t_cmd;

    typedef struct packed {
        logic in_clear;  // pending request is a clear
        logic walk_done;
        logic clr_last;
    } t_sts;

endpackage

// ----- rtl/pstuq_ctrl.sv -----
// ----------------------------------------------------------------------------
// pstuq_ctrl: sequencing state machine
// Accepts one request at a time, runs the walk or the clear sweep, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pstuq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  pstuq_pkg::t_sts   i_sts,
    output pstuq_pkg::t_cmd   o_cmd,
    output pstuq_pkg::t_state o_state
);

    pstuq_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pstuq_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pstuq_pkg::ST_INIT: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = pstuq_pkg::ST_IDLE;
                end
            end
            pstuq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_sts.in_clear ? pstuq_pkg::ST_CLEAR : pstuq_pkg::ST_WALK;
                end
            end
            pstuq_pkg::ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = pstuq_pkg::ST_DONE;
                end
            end
            pstuq_pkg::ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = pstuq_pkg::ST_DONE;
                end
            end
            pstuq_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = pstuq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pstuq_pkg::ST_INIT;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load | (r_out_valid & ~i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule

// ----- rtl/pstuq_dpath.sv -----
// ----------------------------------------------------------------------------
// pstuq_dpath: tree memory, walk address logic and accumulator
// Reads one node per cycle; an add writes the updated node back in the cycle
// after its read, overlapped with the read of the next node.
// ----------------------------------------------------------------------------
module pstuq_dpath #(
    parameter int N = pstuq_pkg::DEF_N
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pstuq_pkg::t_cmd               i_cmd,
    output pstuq_pkg::t_sts               o_sts,
    input  logic [pstuq_pkg::OP_W-1:0]    i_op,
    input  logic [pstuq_pkg::IDX_W-1:0]   i_index,
    input  logic [pstuq_pkg::DATA_W-1:0]  i_delta,
    output logic [pstuq_pkg::DATA_W-1:0]  o_total,
    output logic                          o_bad
);

    localparam int AW  = (N > 1) ? $clog2(N) : 1;       // memory address
    localparam int PW  = $clog2(N + 1) + 1;              // walk position, holds 2N
    localparam int CW  = (PW > pstuq_pkg::IDX_W) ? PW : pstuq_pkg::IDX_W;
    localparam int DW  = pstuq_pkg::DATA_W;

    logic [DW-1:0] r_mem [N];

    logic          r_is_add;
    logic [PW-1:0] r_pos;
    logic [DW-1:0] r_delta;
    logic [DW-1:0] r_acc;
    logic          r_bad;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_addr;
    logic [DW-1:0] r_rd_data;
    logic [AW-1:0] r_clr_addr;
    logic [DW-1:0] r_out_total;
    logic          r_out_bad;

    logic [CW-1:0] idx_ext;
    logic          idx_zero, idx_over;
    logic          in_bad, in_walk;
    logic [PW-1:0] low_bit;
    logic          pos_live, iss;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;

    // request decode
    assign idx_ext  = CW'(i_index);
    assign idx_zero = (i_index == '0);
    assign idx_over = (idx_ext > CW'(N));

    always_comb begin
        in_bad  = 1'b0;
        in_walk = 1'b0;
        case (i_op)
            pstuq_pkg::OP_ADD: begin
                in_bad  = idx_zero | idx_over;
                in_walk = ~(idx_zero | idx_over);
            end
            pstuq_pkg::OP_QUERY: begin
                in_bad  = idx_over;
                in_walk = ~idx_over;
            end
            default: begin
                in_bad  = 1'b0;
                in_walk = 1'b0;
            end
        endcase
    end

    // walk: add climbs by the lowest set bit, query descends
    assign low_bit  = r_pos & (~r_pos + PW'(1));
    assign pos_live = (r_pos != '0) && (r_pos <= PW'(N));
    assign iss      = i_cmd.walk & pos_live;
    assign rd_addr  = AW'(r_pos - PW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_pos    <= in_walk ? PW'(i_index) : '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (iss) begin
                r_pos <= r_is_add ? (r_pos + low_bit) : (r_pos - low_bit);
            end
            r_rd_vld <= iss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_add <= (i_op == pstuq_pkg::OP_ADD);
            r_delta  <= i_delta;
            r_bad    <= in_bad;
            r_acc    <= '0;
        end else if (r_rd_vld && !r_is_add) begin
            r_acc <= r_acc + r_rd_data;
        end
        if (iss) begin
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.out_load) begin
            r_out_total <= r_acc;
            r_out_bad   <= r_bad;
        end
    end

    // clear sweep counter, wraps to zero after the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= (r_clr_addr == AW'(N - 1)) ? '0 : r_clr_addr + AW'(1);
        end
    end

    // single write port: clear sweep or add write-back
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_rd_addr;
        mem_wd = r_rd_data + r_delta;
        if (i_cmd.clr_en) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else if (r_rd_vld && r_is_add) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (iss) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_sts.in_clear  = (i_op == pstuq_pkg::OP_CLEAR);
    assign o_sts.walk_done = ~pos_live & ~r_rd_vld;
    assign o_sts.clr_last  = (r_clr_addr == AW'(N - 1));

    assign o_total = r_out_total;
    assign o_bad   = r_out_bad;

endmodule

// ----- rtl/prefix_sum_tree_update_query.sv -----
// Walk: an add/query visits k nodes (1 <= k <= log2(N)+1) in turn; a new request is
//   taken only after the result of the last one has moved to the output register. A request that
//   visits no node (rejected index, sum at index 0, unused opcode) finishes without a memory read.
// Clear: a sweep over all N entries, one memory write per cycle.
// The single tree RAM port pair (one read, one write per cycle) sets the walk rate.
// Reset: synchronous, active low; then a clearing pass over all N entries with s_axis_tready low.
// ----------------------------------------------------------------------------
// prefix_sum_tree_update_query: binary indexed tree, add / prefix sum / clear
// Holds N signed 32-bit nodes. Each request returns exactly one result.
// ----------------------------------------------------------------------------
module prefix_sum_tree_update_query #(
    parameter int N = pstuq_pkg::DEF_N
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pstuq_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [16:0] index, [48:17] delta
    input  logic [pstuq_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] operation
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pstuq_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [31:0] prefix_total
    output logic                                m_axis_tuser   // [0] bad_index
);

    pstuq_pkg::t_cmd   cmd;
    pstuq_pkg::t_sts   sts;
    pstuq_pkg::t_state state;

    logic [pstuq_pkg::IDX_W-1:0]  req_index;
    logic [pstuq_pkg::DATA_W-1:0] req_delta;

    // unpack request fields
    assign req_index = s_axis_tdata[pstuq_pkg::IDX_W-1:0];
    assign req_delta = s_axis_tdata[pstuq_pkg::IDX_W +: pstuq_pkg::DATA_W];

    // controller: sequencing, request/result handshakes
    pstuq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_state     (state)
    );

    // datapath: tree RAM, walk, accumulator, output register
    pstuq_dpath #(
        .N (N)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_op    (s_axis_tuser),
        .i_index (req_index),
        .i_delta (req_delta),
        .o_total (m_axis_tdata),
        .o_bad   (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // no request taken during the clearing pass
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == pstuq_pkg::ST_INIT) |-> !s_axis_tready)
        else $error("request ready during clearing pass");

    // one request in flight: ready drops right after acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted back to back");

    // a new result appears only out of the done state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(state) == pstuq_pkg::ST_DONE))
        else $error("result valid without finished request");

    // the walk never runs together with a clear sweep
    a_walk_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.walk && cmd.clr_en))
        else $error("walk and clear sweep overlap");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the prefix sum tree block
// Streams add / prefix sum / clear requests into the block and checks every
// result against a binary indexed tree kept in the bench. A directed opening
// covers the index and delta extremes, rejected indexes, the unused opcode
// and a clear; random traffic follows under changing idle and stall phases,
// with one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    import pstuq_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 11;
    localparam int TREE_N         = DEF_N;
    localparam int IDX_MAX        = (1 << IDX_W) - 1;
    localparam int RANDOM_REQS    = 800;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 64;
    // reset clearing pass plus three clear requests dominate; the rest is slack
    localparam int TIMEOUT_CYCLES = 4_000_000;

    // opcode 3 has no name in the package; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // idle phases, cycled every 100 accepted requests
    localparam int PH_NONE = 0;
    localparam int PH_SEND = 1;
    localparam int PH_RECV = 2;
    localparam int PH_BOTH = 3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] delta;
    } t_tree_req;

    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic              bad;
    } t_tree_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [16:0] index, [48:17] delta
    logic [OP_W-1:0]      s_axis_tuser  = '0;  // [1:0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [31:0] prefix_total
    logic                 m_axis_tuser;        // [0] bad_index

    t_tree_req    pending_reqs[$];    // requests not yet offered to the block
    t_tree_result predicted_sums[$];  // results owed by the block, oldest first
    logic [DATA_W-1:0] node_words [1:TREE_N];  // bench copy of the tree

    int  reqs_accepted = 0;
    int  total_reqs    = 0;
    int  mismatches    = 0;
    bit  req_fire      = 1'b0;  // request taken at the last rising edge
    bit  long_hold     = 1'b0;

    prefix_sum_tree_update_query #(
        .N (TREE_N)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Tree model: add climbs by the lowest set bit, prefix sum descends by it.
    // All sums wrap at 32 bits.
    // ------------------------------------------------------------------------
    function automatic t_tree_result apply_request(t_tree_req req);
        t_tree_result res;
        int unsigned  pos;
        res.total = '0;
        res.bad   = 1'b0;
        pos       = req.index;
        case (req.op)
            OP_ADD: begin
                if (pos == 0 || pos > TREE_N) begin
                    res.bad = 1'b1;  // rejected, tree untouched
                end else begin
                    while (pos <= TREE_N) begin
                        node_words[pos] += req.delta;
                        pos += pos & (~pos + 1);
                    end
                end
            end
            OP_QUERY: begin
                if (pos > TREE_N) begin
                    res.bad = 1'b1;
                end else begin
                    // index 0 falls straight through to an empty sum
                    while (pos != 0) begin
                        res.total += node_words[pos];
                        pos -= pos & (~pos + 1);
                    end
                end
            end
            OP_CLEAR: begin
                foreach (node_words[i]) node_words[i] = '0;
            end
            default: ;  // unused opcode: no effect, zero result
        endcase
        return res;
    endfunction

    function automatic int idle_phase();
        return (reqs_accepted / 100) % 4;
    endfunction

    function automatic bit sender_idle();
        case (idle_phase())
            PH_SEND: return $urandom_range(99) < 63;
            PH_BOTH: return $urandom_range(99) < 28;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_phase())
            PH_RECV: return $urandom_range(99) < 63;
            PH_BOTH: return $urandom_range(99) < 28;
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_req(logic [OP_W-1:0] op, int unsigned index, logic [DATA_W-1:0] delta);
        t_tree_req req;
        req.op    = op;
        req.index = index[IDX_W-1:0];
        req.delta = delta;
        pending_reqs.push_back(req);
    endtask

    // valid positions, weighted toward a small dense region and the top end
    // so that adds and prefix sums overlap often
    function automatic int unsigned pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 45) return $urandom_range(32, 1);
        if (r < 65) return $urandom_range(TREE_N, TREE_N - 32);
        return $urandom_range(TREE_N, 1);
    endfunction

    function automatic int unsigned pick_bad_index();
        if ($urandom_range(99) < 30) return 0;
        return $urandom_range(IDX_MAX, TREE_N + 1);
    endfunction

    function automatic logic [DATA_W-1:0] pick_delta();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: one assignment per signal per falling edge. A new
    // request is presented only when the slot is empty or was just taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_tree_req req;
        if (i_rst_n && (!s_axis_tvalid || req_fire)) begin
            if (pending_reqs.size() > 0 && !sender_idle()) begin
                req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(S_TDATA_W - IDX_W - DATA_W){1'b0}}, req.delta, req.index};
                s_axis_tuser  <= req.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, forced low during the long hold-off
    always @(negedge i_clk) begin
        if (long_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !receiver_stall();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted request, checks every accepted
    // result against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tree_req    req;
        t_tree_result want;
        req_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result total=%h bad=%b",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = predicted_sums.pop_front();
                if (m_axis_tdata !== want.total)
                    report_mismatch($sformatf("prefix_total got %h want %h",
                                              m_axis_tdata, want.total));
                if (m_axis_tuser !== want.bad)
                    report_mismatch($sformatf("bad_index got %b want %b",
                                              m_axis_tuser, want.bad));
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            req.op    = s_axis_tuser;
            req.index = s_axis_tdata[IDX_W-1:0];
            req.delta = s_axis_tdata[IDX_W +: DATA_W];
            predicted_sums.push_back(apply_request(req));
            reqs_accepted <= reqs_accepted + 1;
        end
    end

    // long output hold-off during a no-idle phase, so requests keep coming
    // and the block has to stall its input
    initial begin
        wait (reqs_accepted >= 420);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int sel;
        foreach (node_words[i]) node_words[i] = '0;

        // directed: empty sums, wrap at index 1, top index, rejected indexes,
        // unused opcode, longest walks, clear
        queue_req(OP_QUERY, 0, 32'hFFFF_FFFF);
        queue_req(OP_QUERY, 1, '0);
        queue_req(OP_ADD, 1, 32'h7FFF_FFFF);
        queue_req(OP_ADD, 1, 32'h0000_0001);          // wraps to most negative
        queue_req(OP_ADD, TREE_N, 32'h8000_0000);
        queue_req(OP_ADD, 0, 32'hFFFF_FFFF);          // add at zero: rejected
        queue_req(OP_ADD, TREE_N + 1, 32'h1234_5678); // add above N: rejected
        queue_req(OP_ADD, IDX_MAX, 32'h5555_5555);
        queue_req(OP_QUERY, TREE_N, '0);
        queue_req(OP_QUERY, TREE_N + 1, '0);          // sum above N: rejected
        queue_req(OP_QUERY, IDX_MAX, 32'hAAAA_AAAA);
        queue_req(OP_UNUSED, 5, 32'hDEAD_BEEF);
        queue_req(OP_ADD, 3, 32'hFFFF_FFFB);
        queue_req(OP_ADD, 32768, 32'hFFFF_FFFF);
        queue_req(OP_QUERY, 65535, '0);               // sixteen-node descent
        queue_req(OP_QUERY, 3, '0);
        queue_req(OP_QUERY, 32767, '0);
        queue_req(OP_UNUSED, IDX_MAX, '0);
        queue_req(OP_CLEAR, 7, 32'hFFFF_FFFF);
        queue_req(OP_QUERY, TREE_N, '0);
        queue_req(OP_QUERY, 1, '0);
        queue_req(OP_ADD, 2, 32'd123);
        queue_req(OP_QUERY, 2, '0);

        // random: mostly adds and sums over overlapping positions, a little
        // noise, two clears placed to keep the sweep time bounded
        for (int n = 0; n < RANDOM_REQS; n++) begin
            sel = $urandom_range(99);
            if (n == 266 || n == 533) begin
                queue_req(OP_CLEAR, $urandom_range(IDX_MAX), $urandom());
            end else if (sel < 48) begin
                queue_req(OP_ADD, pick_index(), pick_delta());
            end else if (sel < 92) begin
                queue_req(OP_QUERY, pick_index(), $urandom());
            end else if (sel < 97) begin
                queue_req(sel[0] ? OP_ADD : OP_QUERY, pick_bad_index(), $urandom());
            end else begin
                queue_req(OP_UNUSED, $urandom_range(IDX_MAX), $urandom());
            end
        end
        total_reqs = pending_reqs.size();

        // synchronous reset, released at a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (reqs_accepted == total_reqs);
        wait (predicted_sums.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && predicted_sums.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
